@@ src/fcpp_pkg.sv @@
// shared types and constants for the four channel position pid block
// no dependencies

package fcpp_pkg;

    localparam int LANES           = 4;
    localparam int LANE_W          = 2;
    localparam int INTEGRAL_WINDOW = 40;

    localparam int CNT_W  = 24;
    localparam int ERR_W  = CNT_W + 1;
    localparam int INT_W  = 20;
    localparam int DER_W  = ERR_W + 1;
    localparam int SUM_W  = ERR_W + 1;
    localparam int GAIN_W = 16;
    localparam int DRV_W  = 8;
    localparam int PRP_W  = GAIN_W + ERR_W;
    localparam int PRI_W  = GAIN_W + INT_W;
    localparam int PRD_W  = GAIN_W + DER_W;
    localparam int ACC_W  = PRD_W + 2;
    localparam int FRAC_W = 8;
    localparam int QUO_W  = ACC_W - FRAC_W;

    localparam int QDEPTH = 3;
    localparam int QPTR_W = 2;
    localparam int PEND_W = 2;

    localparam int CFG_IDX_W = 2;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = GAIN_W'(256);
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = '0;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = '0;

    localparam logic signed [ERR_W-1:0] WIN_POS = ERR_W'(INTEGRAL_WINDOW);
    localparam logic signed [ERR_W-1:0] WIN_NEG = -WIN_POS;

    localparam logic signed [SUM_W-1:0] INT_MAX = SUM_W'((1 << (INT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] INT_MIN = -SUM_W'(1 << (INT_W - 1));

    localparam logic signed [QUO_W-1:0] DRV_MAX = QUO_W'(127);
    localparam logic signed [QUO_W-1:0] DRV_MIN = -DRV_MAX;
    localparam logic signed [ACC_W-1:0] DIV_BIAS = ACC_W'((1 << FRAC_W) - 1);

    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P = 2'd0,
        CFG_GAIN_I = 2'd1,
        CFG_GAIN_D = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic                valid;
        logic [LANE_W-1:0]   lane;
        logic                start;
        logic                zt;
        logic                done;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [INT_W-1:0] integ;
        logic signed [ERR_W-1:0] last;
    } state_word_t;

    typedef struct packed {
        logic                     done;
        logic [LANES*DRV_W-1:0]   drv;
    } result_t;

endpackage

@@ src/fcpp_lane_update.sv @@
// per lane state memory with read, update and write back of integral and last error
// depends on fcpp_pkg

module fcpp_lane_update
    import fcpp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lane_ctl_t                iss_ctl,
    input  logic signed [CNT_W-1:0]  iss_tgt,
    input  logic signed [CNT_W-1:0]  iss_cnt,
    output lane_ctl_t                upd_ctl,
    output logic signed [ERR_W-1:0]  upd_err,
    output logic signed [INT_W-1:0]  upd_integ,
    output logic signed [DER_W-1:0]  upd_deriv
);

    state_word_t              mem [LANES];
    logic [LANES-1:0]         vld_reg;
    state_word_t              rd_data_reg;
    logic                     rd_ok_reg;

    lane_ctl_t                ctl1_reg;
    logic signed [CNT_W-1:0]  tgt1_reg;
    logic signed [CNT_W-1:0]  cnt1_reg;

    lane_ctl_t                ctl2_reg;
    logic signed [ERR_W-1:0]  err2_reg;
    logic signed [INT_W-1:0]  integ2_reg;
    logic signed [DER_W-1:0]  deriv2_reg;

    logic signed [ERR_W-1:0]  tgt_ext;
    logic signed [ERR_W-1:0]  err;
    logic signed [INT_W-1:0]  old_integ;
    logic signed [ERR_W-1:0]  old_last;
    logic signed [SUM_W-1:0]  int_sum;
    logic signed [INT_W-1:0]  integ_next;
    logic signed [DER_W-1:0]  deriv;
    logic                     mem_we;
    state_word_t              wr_word;
    lane_ctl_t                ctl2_next;

    // registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[iss_ctl.lane];
        tgt1_reg    <= iss_tgt;
        cnt1_reg    <= iss_cnt;
        if (!aresetn) begin
            ctl1_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            ctl1_reg  <= iss_ctl;
            rd_ok_reg <= vld_reg[iss_ctl.lane];
        end
    end

    always_comb begin
        tgt_ext = ERR_W'(tgt1_reg);
        err     = ERR_W'(tgt1_reg) - ERR_W'(cnt1_reg);

        if (ctl1_reg.start || !rd_ok_reg) begin
            old_integ = '0;
        end else begin
            old_integ = rd_data_reg.integ;
        end
        if (ctl1_reg.start) begin
            old_last = tgt_ext;
        end else if (!rd_ok_reg) begin
            old_last = '0;
        end else begin
            old_last = rd_data_reg.last;
        end

        int_sum = SUM_W'(old_integ) + SUM_W'(err);
        priority if (err == '0 || err > WIN_POS || err < WIN_NEG) begin
            integ_next = '0;
        end else if (int_sum > INT_MAX) begin
            integ_next = INT_MAX[INT_W-1:0];
        end else if (int_sum < INT_MIN) begin
            integ_next = INT_MIN[INT_W-1:0];
        end else begin
            integ_next = int_sum[INT_W-1:0];
        end

        deriv = DER_W'(err) - DER_W'(old_last);

        // zero target leaves state alone unless a move starts
        mem_we = ctl1_reg.valid && (!ctl1_reg.zt || ctl1_reg.start);
        if (ctl1_reg.zt) begin
            wr_word.integ = '0;
            wr_word.last  = tgt_ext;
        end else begin
            wr_word.integ = integ_next;
            wr_word.last  = err;
        end

        ctl2_next      = ctl1_reg;
        ctl2_next.done = ctl1_reg.zt || (err == '0);
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ctl1_reg.lane] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (mem_we) begin
            vld_reg[ctl1_reg.lane] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        err2_reg   <= err;
        integ2_reg <= integ_next;
        deriv2_reg <= deriv;
        if (!aresetn) begin
            ctl2_reg <= '0;
        end else begin
            ctl2_reg <= ctl2_next;
        end
    end

    assign upd_ctl   = ctl2_reg;
    assign upd_err   = err2_reg;
    assign upd_integ = integ2_reg;
    assign upd_deriv = deriv2_reg;

endmodule

@@ src/fcpp_drive_calc.sv @@
// gain multiply, sum, divide by 256 toward zero and drive saturation for one lane
// depends on fcpp_pkg

module fcpp_drive_calc
    import fcpp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic signed [GAIN_W-1:0]  gain_p,
    input  logic signed [GAIN_W-1:0]  gain_i,
    input  logic signed [GAIN_W-1:0]  gain_d,
    input  lane_ctl_t                 upd_ctl,
    input  logic signed [ERR_W-1:0]   upd_err,
    input  logic signed [INT_W-1:0]   upd_integ,
    input  logic signed [DER_W-1:0]   upd_deriv,
    output lane_ctl_t                 drv_ctl,
    output logic signed [DRV_W-1:0]   drv_value
);

    lane_ctl_t                ctl3_reg;
    logic signed [PRP_W-1:0]  prp_reg;
    logic signed [PRI_W-1:0]  pri_reg;
    logic signed [PRD_W-1:0]  prd_reg;

    lane_ctl_t                ctl4_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [ACC_W-1:0]  acc_adj;
    logic signed [QUO_W-1:0]  quo;

    always_ff @(posedge aclk) begin
        prp_reg <= gain_p * upd_err;
        pri_reg <= gain_i * upd_integ;
        prd_reg <= gain_d * upd_deriv;
        if (!aresetn) begin
            ctl3_reg <= '0;
        end else begin
            ctl3_reg <= upd_ctl;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= ACC_W'(prp_reg) + ACC_W'(pri_reg) + ACC_W'(prd_reg);
        if (!aresetn) begin
            ctl4_reg <= '0;
        end else begin
            ctl4_reg <= ctl3_reg;
        end
    end

    always_comb begin
        // bias negatives so the shift truncates toward zero
        acc_adj = acc_reg[ACC_W-1] ? (acc_reg + DIV_BIAS) : acc_reg;
        quo     = acc_adj[ACC_W-1:FRAC_W];
        priority if (ctl4_reg.zt) begin
            drv_value = '0;
        end else if (quo > DRV_MAX) begin
            drv_value = DRV_MAX[DRV_W-1:0];
        end else if (quo < DRV_MIN) begin
            drv_value = DRV_MIN[DRV_W-1:0];
        end else begin
            drv_value = quo[DRV_W-1:0];
        end
    end

    assign drv_ctl = ctl4_reg;

endmodule

@@ src/fcpp_result_queue.sv @@
// small result queue that decouples the lane pipeline from the output channel
// depends on fcpp_pkg

module fcpp_result_queue
    import fcpp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  result_t  push_data,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  out_data
);

    result_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]    head_reg;
    logic [QPTR_W-1:0]    tail_reg;
    logic [QPTR_W-1:0]    count_reg;
    logic [QPTR_W-1:0]    head_next;
    logic [QPTR_W-1:0]    tail_next;
    logic [QPTR_W-1:0]    count_next;
    logic                 pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = q_mem[head_reg];
    assign pop       = out_valid && out_ready;

    always_comb begin
        head_next  = (head_reg == QPTR_W'(QDEPTH - 1)) ? '0 : head_reg + 1'b1;
        tail_next  = (tail_reg == QPTR_W'(QDEPTH - 1)) ? '0 : tail_reg + 1'b1;
        count_next = count_reg + QPTR_W'(push) - QPTR_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (pop) begin
                head_reg <= head_next;
            end
            if (push) begin
                tail_reg <= tail_next;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ src/four_channel_pid_position.sv @@
// Four channel position PID controller with integral reset.
// Slave channel s_*: one control tick per transaction, four targets, four encoder
// counts and the start flag. Master channel m_*: four saturated drives and the done flag.
// Gains are written through cfg_we / cfg_index / cfg_data; the user must write them only
// while the block is idle, which the block does not enforce; index 0 proportional,
// 1 integral, 2 derivative, all signed Q8.8. The per channel integral and last error live
// in a four entry memory with a registered read port; one channel is read, updated and
// written back per cycle. A new transaction is not accepted before the last of the four
// channels of the previous one is issued, as the lane sequencer walks them in turn.
// Each result is registered in fcpp_lane_update and fcpp_drive_calc before the buffer.
// Up to three results are buffered; when the receiver stalls, s_tready drops once
// three transactions are accepted but not yet delivered, and nothing is lost.
// Reset clears the integrals and last errors to zero, the gains to 1.0, 0 and 0,
// and empties the pipeline and the result buffer.
// depends on fcpp_pkg, fcpp_lane_update, fcpp_drive_calc, fcpp_result_queue

module four_channel_pid_position
    import fcpp_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [GAIN_W-1:0]         cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // target_rb, target_lb, target_rf, target_lf, count_rb, count_lb, count_rf, count_lf
    input  logic [2*LANES*CNT_W-1:0]  s_tdata,
    // start_req
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // drive_rb, drive_lb, drive_rf, drive_lf
    output logic [LANES*DRV_W-1:0]    m_tdata,
    // done_res
    output logic                      m_tuser
);

    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;

    logic signed [CNT_W-1:0]   tgt_reg [LANES];
    logic signed [CNT_W-1:0]   cnt_reg [LANES];
    logic                      start_reg;
    logic                      zt_reg;
    logic                      in_valid_reg;
    logic [LANE_W-1:0]         lane_reg;
    logic [PEND_W-1:0]         pend_reg;
    logic [PEND_W-1:0]         pend_next;

    logic                      s_acc;
    logic                      m_acc;
    logic                      zt_in;
    lane_ctl_t                 iss_ctl;

    lane_ctl_t                 upd_ctl;
    logic signed [ERR_W-1:0]   upd_err;
    logic signed [INT_W-1:0]   upd_integ;
    logic signed [DER_W-1:0]   upd_deriv;
    lane_ctl_t                 drv_ctl;
    logic signed [DRV_W-1:0]   drv_value;

    logic [LANES*DRV_W-1:0]    asm_drv_reg;
    logic                      asm_done_reg;
    logic                      asm_done_next;
    logic                      push;
    result_t                   push_data;
    result_t                   out_data;

    // gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg <= GAIN_P_RST;
            gain_i_reg <= GAIN_I_RST;
            gain_d_reg <= GAIN_D_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_GAIN_P: gain_p_reg <= cfg_data;
                CFG_GAIN_I: gain_i_reg <= cfg_data;
                CFG_GAIN_D: gain_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // input capture and lane sequencer
    assign s_tready = (!in_valid_reg || lane_reg == LANE_LAST) && (pend_reg < PEND_W'(QDEPTH));
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    always_comb begin
        zt_in = 1'b0;
        for (int k = 0; k < LANES; k++) begin
            if (s_tdata[k*CNT_W +: CNT_W] == '0) begin
                zt_in = 1'b1;
            end
        end
        pend_next = pend_reg + PEND_W'(s_acc) - PEND_W'(m_acc);
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            for (int k = 0; k < LANES; k++) begin
                tgt_reg[k] <= s_tdata[k*CNT_W +: CNT_W];
                cnt_reg[k] <= s_tdata[(LANES+k)*CNT_W +: CNT_W];
            end
            start_reg <= s_tuser;
            zt_reg    <= zt_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            lane_reg     <= '0;
            pend_reg     <= '0;
        end else begin
            pend_reg <= pend_next;
            if (in_valid_reg) begin
                if (lane_reg == LANE_LAST) begin
                    in_valid_reg <= s_acc;
                    lane_reg     <= '0;
                end else begin
                    lane_reg <= lane_reg + 1'b1;
                end
            end else if (s_acc) begin
                in_valid_reg <= 1'b1;
                lane_reg     <= '0;
            end
        end
    end

    always_comb begin
        iss_ctl.valid = in_valid_reg;
        iss_ctl.lane  = lane_reg;
        iss_ctl.start = start_reg;
        iss_ctl.zt    = zt_reg;
        iss_ctl.done  = 1'b0;
    end

    fcpp_lane_update u_lane_update (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .iss_ctl   (iss_ctl),
        .iss_tgt   (tgt_reg[lane_reg]),
        .iss_cnt   (cnt_reg[lane_reg]),
        .upd_ctl   (upd_ctl),
        .upd_err   (upd_err),
        .upd_integ (upd_integ),
        .upd_deriv (upd_deriv)
    );

    fcpp_drive_calc u_drive_calc (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .upd_ctl   (upd_ctl),
        .upd_err   (upd_err),
        .upd_integ (upd_integ),
        .upd_deriv (upd_deriv),
        .drv_ctl   (drv_ctl),
        .drv_value (drv_value)
    );

    // gather the four lanes of one transaction
    always_comb begin
        asm_done_next  = ((drv_ctl.lane == '0) ? 1'b0 : asm_done_reg) | drv_ctl.done;
        push           = drv_ctl.valid && (drv_ctl.lane == LANE_LAST);
        push_data.done = asm_done_next;
        push_data.drv  = {drv_value, asm_drv_reg[(LANES-1)*DRV_W-1:0]};
    end

    always_ff @(posedge aclk) begin
        if (drv_ctl.valid) begin
            asm_drv_reg[drv_ctl.lane*DRV_W +: DRV_W] <= drv_value;
            asm_done_reg                             <= asm_done_next;
        end
    end

    fcpp_result_queue u_result_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = out_data.drv;
    assign m_tuser = out_data.done;

endmodule

@@ bench/pid_drive_checker.sv @@
`timescale 1ns / 100ps
// pid_drive_checker: watches the gain port and both streams of four_channel_pid_position,
// keeps its own gains, integrals and last errors and checks every drive result in order
// depends on fcpp_pkg

module pid_drive_checker
    import fcpp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [GAIN_W-1:0]        cfg_data,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [2*LANES*CNT_W-1:0] s_tdata,
    input  logic                     s_tuser,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [LANES*DRV_W-1:0]   m_tdata,
    input  logic                     m_tuser,
    output int                       fail_count,
    output int                       pending,
    output int                       ticks_checked,
    output int                       done_seen,
    output int                       drive_clamps,
    output int                       integ_sats
);

    localparam longint INTEG_HI = 524287;
    localparam longint INTEG_LO = -524288;
    localparam longint DRIVE_HI = 127;

    longint  kp, ki, kd;
    longint  integ_sum [LANES];
    longint  prev_err [LANES];
    result_t expected_drives [$];
    int      n_fail = 0;
    int      n_ticks = 0;
    int      n_done = 0;
    int      n_clamp = 0;
    int      n_sat = 0;

    function automatic longint bound(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_fail(input string msg);
        // only the first hundred are printed, all are counted
        if (n_fail < 100) $display("[%0t] %s", $time, msg);
        n_fail++;
    endtask

    task automatic predict_drives(input logic start, input logic [2*LANES*CNT_W-1:0] data);
        longint  tgt [LANES];
        longint  cnt [LANES];
        longint  err, sum, integ, acc, drv;
        logic    zero_tgt;
        result_t res;
        zero_tgt = 1'b0;
        res = '0;
        for (int i = 0; i < LANES; i++) begin
            tgt[i] = longint'($signed(data[i*CNT_W +: CNT_W]));
            cnt[i] = longint'($signed(data[(LANES+i)*CNT_W +: CNT_W]));
            if (tgt[i] == 0) zero_tgt = 1'b1;
        end
        if (start) begin
            for (int i = 0; i < LANES; i++) begin
                integ_sum[i] = 0;
                prev_err[i] = tgt[i];
            end
        end
        if (zero_tgt) begin
            res.done = 1'b1;
            expected_drives.push_back(res);
            return;
        end
        for (int i = 0; i < LANES; i++) begin
            err = tgt[i] - cnt[i];
            sum = integ_sum[i] + err;
            integ = bound(sum, INTEG_LO, INTEG_HI);
            if (err == 0 || err > INTEGRAL_WINDOW || err < -INTEGRAL_WINDOW) integ = 0;
            else if (integ != sum) n_sat++;
            acc = kp * err + ki * integ + kd * (err - prev_err[i]);
            integ_sum[i] = integ;
            prev_err[i] = err;
            if (err == 0) res.done = 1'b1;
            drv = bound(acc / 256, -DRIVE_HI, DRIVE_HI);
            if (drv != acc / 256) n_clamp++;
            res.drv[i*DRV_W +: DRV_W] = DRV_W'(drv);
        end
        expected_drives.push_back(res);
    endtask

    task automatic check_result(input logic [LANES*DRV_W-1:0] drives, input logic done);
        result_t want;
        if (expected_drives.size() == 0) begin
            report_fail($sformatf("result with no tick pending: drives %h done %b",
                                  drives, done));
            return;
        end
        want = expected_drives.pop_front();
        n_ticks++;
        if (want.done) n_done++;
        for (int i = 0; i < LANES; i++) begin
            if (drives[i*DRV_W +: DRV_W] !== want.drv[i*DRV_W +: DRV_W])
                report_fail($sformatf("tick %0d lane %0d drive %0d, expected %0d", n_ticks, i,
                                      $signed(drives[i*DRV_W +: DRV_W]),
                                      $signed(want.drv[i*DRV_W +: DRV_W])));
        end
        if (done !== want.done)
            report_fail($sformatf("tick %0d done %b, expected %b", n_ticks, done, want.done));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            kp = 256;
            ki = 0;
            kd = 0;
            for (int i = 0; i < LANES; i++) begin
                integ_sum[i] = 0;
                prev_err[i] = 0;
            end
            expected_drives.delete();
        end else begin
            // results first so a tick accepted on this edge cannot be matched early
            if (m_tvalid && m_tready) check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) predict_drives(s_tuser, s_tdata);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_GAIN_P: kp = longint'($signed(cfg_data));
                    CFG_GAIN_I: ki = longint'($signed(cfg_data));
                    CFG_GAIN_D: kd = longint'($signed(cfg_data));
                    default: ;
                endcase
            end
        end
        fail_count    <= n_fail;
        pending       <= expected_drives.size();
        ticks_checked <= n_ticks;
        done_seen     <= n_done;
        drive_clamps  <= n_clamp;
        integ_sats    <= n_sat;
    end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// tb: stimulus and verdict for four_channel_pid_position, gain writes between phases and
// control ticks in random bursts against a stalling receiver; pid_drive_checker checks
// depends on fcpp_pkg, four_channel_pid_position, pid_drive_checker

module tb;
    import fcpp_pkg::*;

    localparam int     CYCLE_LIMIT   = 200_000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     MOVE_ITEMS    = 150;
    localparam int     GAIN_PHASES   = 8;
    localparam longint CNT_HI        = 8388607;
    localparam longint CNT_LO        = -8388608;

    localparam logic [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
    localparam logic [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

    typedef logic [LANES-1:0][CNT_W-1:0] lane_vec_t;
    typedef enum int {READY_ALWAYS, READY_COIN, READY_ONE_IN_FIVE, READY_RARE} rx_pattern_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [GAIN_W-1:0]        cfg_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [2*LANES*CNT_W-1:0] s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [LANES*DRV_W-1:0]   m_tdata;
    logic                     m_tuser;

    int          fail_count, pending, ticks_checked, done_seen, drive_clamps, integ_sats;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          ticks_sent = 0;
    int          phases_run = 0;
    int          mode_left = 0;
    rx_pattern_t rx_mode = READY_ALWAYS;

    four_channel_pid_position u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    pid_drive_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending       (pending),
        .ticks_checked (ticks_checked),
        .done_seen     (done_seen),
        .drive_clamps  (drive_clamps),
        .integ_sats    (integ_sats)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // receiver back-pressure, switching to a random pattern whenever mode_left runs out
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            rx_mode <= rx_pattern_t'($urandom_range(0, 3));
            mode_left <= $urandom_range(40, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            READY_ALWAYS:      m_tready <= 1'b1;
            READY_COIN:        m_tready <= 1'($urandom_range(0, 1));
            READY_ONE_IN_FIVE: m_tready <= (cycle_count % 5 == 0);
            default:           m_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    task automatic send_tick(input logic start, input lane_vec_t tgt, input lane_vec_t cnt);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= start;
        s_tdata <= {cnt, tgt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        ticks_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                              input logic [GAIN_W-1:0] kd);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_GAIN_P;
        cfg_data <= kp;
        @(posedge aclk);
        cfg_index <= CFG_GAIN_I;
        cfg_data <= ki;
        @(posedge aclk);
        cfg_index <= CFG_GAIN_D;
        cfg_data <= kd;
        @(posedge aclk);
        cfg_we <= 1'b0;
        phases_run++;
    endtask

    task automatic directed_ticks();
        lane_vec_t t, c;
        // zero error on every lane
        send_tick(1'b1, {LANES{CNT_W'(100)}}, {LANES{CNT_W'(100)}});
        // full scale errors both ways
        send_tick(1'b1, {LANES{CNT_MAX}}, {LANES{CNT_MIN}});
        send_tick(1'b0, {LANES{CNT_MIN}}, {LANES{CNT_MAX}});
        // error right at the window edge, twice so the integral builds
        send_tick(1'b0, {LANES{CNT_MAX}}, {LANES{CNT_MAX - CNT_W'(40)}});
        send_tick(1'b0, {LANES{CNT_MAX}}, {LANES{CNT_MAX - CNT_W'(40)}});
        // lanes rb, lb, rf, lf at +40, -40, -41, +1, then rb reaches zero
        t = {LANES{CNT_W'(1000)}};
        c = {CNT_W'(999), CNT_W'(1041), CNT_W'(1040), CNT_W'(960)};
        send_tick(1'b0, t, c);
        c[0] = CNT_W'(1000);
        send_tick(1'b0, t, c);
        // one zero target, with and without start, then all targets zero
        t = {CNT_W'(12), CNT_W'(0), CNT_W'(7), -CNT_W'(5)};
        send_tick(1'b1, t, c);
        send_tick(1'b0, t, c);
        send_tick(1'b0, '0, {LANES{CNT_MAX}});
        send_tick(1'b0, {LANES{-CNT_W'(1)}}, '0);
        send_tick(1'b1, {LANES{CNT_W'(1)}}, {LANES{CNT_MIN}});
        send_tick(1'b0, {LANES{CNT_MIN}}, {LANES{CNT_MIN}});
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("Verification failed");
        $finish;
    end

    initial begin
        lane_vec_t                tgt, tick_tgt, cnt;
        longint                   err, c, mag;
        int                       len, stop, r;
        bit                       settle, fresh;
        logic signed [GAIN_W-1:0] kp, ki, kd;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        directed_ticks();
        load_gains(16'sh7fff, 16'sh8000, 16'sh7fff);
        directed_ticks();

        for (int p = 0; p < GAIN_PHASES; p++) begin
            case (p)
                0: begin kp = 16'sh7fff; ki = 16'sh7fff; kd = 16'sh7fff; end
                1: begin kp = 16'sh8000; ki = 16'sh8000; kd = 16'sh8000; end
                2: begin kp = '0; ki = '0; kd = '0; end
                3: begin kp = 16'sd256; ki = 16'sd64; kd = 16'sd128; end
                7: begin
                    kp = GAIN_W'($urandom);
                    ki = GAIN_W'($urandom);
                    kd = GAIN_W'($urandom);
                end
                default: begin
                    kp = GAIN_W'(int'($urandom_range(0, 1200)) - 600);
                    ki = GAIN_W'(int'($urandom_range(0, 400)) - 200);
                    kd = GAIN_W'(int'($urandom_range(0, 800)) - 400);
                end
            endcase
            load_gains(kp, ki, kd);

            stop = ticks_sent + MOVE_ITEMS;
            while (ticks_sent < stop) begin
                if ($urandom_range(0, 9) == 0) begin
                    // noise: any bit pattern, start at random
                    tgt = {$urandom, $urandom, $urandom};
                    cnt = {$urandom, $urandom, $urandom};
                    send_tick(1'($urandom_range(0, 1)), tgt, cnt);
                end else begin
                    len = $urandom_range(2, 30);
                    settle = 1'($urandom_range(0, 1));
                    fresh = ($urandom_range(0, 19) != 0);
                    for (int i = 0; i < LANES; i++) begin
                        r = $urandom_range(0, 9);
                        if (r < 5) mag = $urandom_range(1, 2000);
                        else if (r < 8) mag = $urandom_range(1, 200000);
                        else mag = $urandom_range(1, 8388607);
                        tgt[i] = CNT_W'($urandom_range(0, 1) ? -mag : mag);
                    end
                    for (int k = 0; k < len && ticks_sent < stop; k++) begin
                        for (int i = 0; i < LANES; i++) begin
                            r = $urandom_range(0, 99);
                            if (r < (settle ? 6 : 12)) mag = 0;
                            else if (r < (settle ? 12 : 20)) mag = $urandom_range(40, 41);
                            else if (r < (settle ? 95 : 55)) mag = $urandom_range(1, 40);
                            else if (r < (settle ? 100 : 85)) mag = $urandom_range(42, 5000);
                            else mag = $urandom_range(5001, 4000000);
                            err = $urandom_range(0, 1) ? -mag : mag;
                            c = longint'($signed(tgt[i])) - err;
                            if (c > CNT_HI || c < CNT_LO) c = longint'($signed(tgt[i])) + err;
                            cnt[i] = CNT_W'(c);
                        end
                        tick_tgt = tgt;
                        if ($urandom_range(0, 49) == 0)
                            tick_tgt[$urandom_range(0, LANES - 1)] = '0;
                        send_tick(fresh && k == 0, tick_tgt, cnt);
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("%0d ticks checked over %0d gain settings after reset defaults", ticks_checked,
                 phases_run);
        $display("%0d done results, %0d drive clamps, %0d saturated integral updates",
                 done_seen, drive_clamps, integ_sats);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/fcpp_pkg.sv
src/fcpp_lane_update.sv
src/fcpp_drive_calc.sv
src/fcpp_result_queue.sv
src/four_channel_pid_position.sv
bench/pid_drive_checker.sv
bench/tb.sv
